// ===== sv/pts_rectifier_macros.svh =====
// Assertion helpers for the timestamp rectifier.
`ifndef PTS_RECTIFIER_MACROS_SVH
`define PTS_RECTIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pts_rectifier: assertion failed");

`define PTS_ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pts_rectifier: assertion failed");

`else

`define PTS_ASSERT(lbl, clk, rst_n, prop)

`define PTS_ASSERT_CLK(lbl, clk, prop)

`endif

`endif

// ===== sv/pts_rect_pkg.sv =====
package pts_rect_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 48;

  localparam int DUR_W  = 26;
  localparam int LAST_W = 64;
  localparam int PTS_W  = 32;
  localparam int CFG_W  = 26;
  localparam int IDX_W  = 2;
  localparam int FUNC_W = 2;

  localparam logic [DUR_W-1:0] AUDIO_DUR_RST = DUR_W'(1398101);
  localparam logic [DUR_W-1:0] VIDEO_DUR_RST = DUR_W'(2621440);

  localparam logic [PTS_W:0] PTS_MOD = {1'b0, 32'hffff_ffff};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RESET = 2'd0,
    FUNC_AUDIO = 2'd1,
    FUNC_VIDEO = 2'd2
  } func_e;

  typedef enum logic [IDX_W-1:0] {
    REG_AUDIO_DUR  = 2'd0,
    REG_VIDEO_DUR  = 2'd1,
    REG_AUDIO_RECT = 2'd2,
    REG_VIDEO_RECT = 2'd3
  } reg_idx_e;

  // 2^32 == 1 mod (2^32 - 1): fold the high word onto the low word, then
  // one conditional subtract (upper word is under 2^24 for any legal shift).
  function automatic logic [PTS_W-1:0] pts_mod(input logic [LAST_W-1:0] v);
    logic [PTS_W:0] sum;
    logic [PTS_W:0] red;
    sum = {1'b0, v[LAST_W-1:PTS_W]} + {1'b0, v[PTS_W-1:0]};
    red = (sum >= PTS_MOD) ? (sum - PTS_MOD) : sum;
    return red[PTS_W-1:0];
  endfunction

endpackage

// ===== sv/pts_rectifier.sv =====
// An accepted input beat reaches its result beat through the input register,
// then the result register; out_stall_i can hold the beat in either.
// Throughput: one beat per cycle while out_stall_i is low; the update of the per-stream
// last timestamp as each beat fires sets the pace. Reset and unused selectors give no result.
// Reset (rst_ni low, async): valids cleared, start time and last timestamps
// zero, frame durations and rectify flags at their defaults.
`include "pts_rectifier_macros.svh"

module pts_rectifier #(
  parameter int FRAC_BITS = pts_rect_pkg::FRAC_BITS_DEF,
  parameter int TIME_BITS = pts_rect_pkg::TIME_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pts_rect_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [pts_rect_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pts_rect_pkg::FUNC_W-1:0]    func_i,
  input  logic [TIME_BITS-1:0]               now_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pts_rect_pkg::PTS_W-1:0]     pts_o,
  output logic                               stream_o
);
  import pts_rect_pkg::*;

  logic [DUR_W-1:0]     adur_q, adur_d, vdur_q, vdur_d;
  logic                 arect_q, arect_d, vrect_q, vrect_d;

  logic                 in_valid_q, in_valid_d;
  logic [FUNC_W-1:0]    func_q;
  logic [TIME_BITS-1:0] now_q;

  logic [TIME_BITS-1:0] start_q, start_d;
  logic [LAST_W-1:0]    alast_q, alast_d, vlast_q, vlast_d;

  logic                 out_valid_q, out_valid_d;
  logic [PTS_W-1:0]     pts_q;
  logic                 stream_q;

  logic                 adv, in_ready, load_in, fire, is_audio, is_video, has_res;
  logic [DUR_W-1:0]     sel_dur;
  logic [LAST_W-1:0]    sel_last, pred, pred_ms, el64, diff, thresh, new_last, new_ms;
  logic                 sel_rect, hit;
  logic [TIME_BITS-1:0] elapsed;
  logic [PTS_W-1:0]     pts_d;

  // handshake
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || adv;
  assign in_stall_o = !in_ready;
  assign load_in    = in_valid_i && in_ready;
  assign fire       = in_valid_q && adv;

  assign is_audio = (func_e'(func_q) == FUNC_AUDIO);
  assign is_video = (func_e'(func_q) == FUNC_VIDEO);
  assign has_res  = is_audio || is_video;

  // datapath
  assign elapsed  = now_q - start_q;
  assign sel_dur  = is_video ? vdur_q  : adur_q;
  assign sel_last = is_video ? vlast_q : alast_q;
  assign sel_rect = is_video ? vrect_q : arect_q;

  assign pred     = sel_last + LAST_W'(sel_dur);
  assign pred_ms  = pred >> FRAC_BITS;
  assign el64     = LAST_W'(elapsed);
  assign diff     = (el64 >= pred_ms) ? (el64 - pred_ms) : (pred_ms - el64);
  assign thresh   = LAST_W'(sel_dur) >> (FRAC_BITS + 1);
  assign hit      = sel_rect && (diff < thresh);
  assign new_last = hit ? pred : (el64 << FRAC_BITS);
  assign new_ms   = new_last >> FRAC_BITS;
  assign pts_d    = pts_mod(new_ms);

  always_comb begin
    adur_d  = adur_q;
    vdur_d  = vdur_q;
    arect_d = arect_q;
    vrect_d = vrect_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_AUDIO_DUR:  adur_d  = cfg_data_i[DUR_W-1:0];
        REG_VIDEO_DUR:  vdur_d  = cfg_data_i[DUR_W-1:0];
        REG_AUDIO_RECT: arect_d = cfg_data_i[0];
        REG_VIDEO_RECT: vrect_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_valid_d  = in_ready ? in_valid_i : in_valid_q;
    out_valid_d = adv ? (in_valid_q && has_res) : out_valid_q;
    start_d     = start_q;
    alast_d     = alast_q;
    vlast_d     = vlast_q;
    if (fire) begin
      case (func_e'(func_q))
        FUNC_RESET: start_d = now_q;
        FUNC_AUDIO: alast_d = new_last;
        FUNC_VIDEO: vlast_d = new_last;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adur_q      <= AUDIO_DUR_RST;
      vdur_q      <= VIDEO_DUR_RST;
      arect_q     <= 1'b1;
      vrect_q     <= 1'b1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      start_q     <= '0;
      alast_q     <= '0;
      vlast_q     <= '0;
    end else begin
      adur_q      <= adur_d;
      vdur_q      <= vdur_d;
      arect_q     <= arect_d;
      vrect_q     <= vrect_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      start_q     <= start_d;
      alast_q     <= alast_d;
      vlast_q     <= vlast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      func_q <= func_i;
      now_q  <= now_ms_i;
    end
    if (fire && has_res) begin
      pts_q    <= pts_d;
      stream_q <= is_video;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pts_o       = pts_q;
  assign stream_o    = stream_q;

  `PTS_ASSERT(a_rose_needs_req, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_q && (func_q == FUNC_AUDIO || func_q == FUNC_VIDEO)))
  `PTS_ASSERT(a_pts_below_mod, clk_i, rst_ni, out_valid_o |-> (pts_o != PTS_MOD[PTS_W-1:0]))
  `PTS_ASSERT(a_video_stream, clk_i, rst_ni, (fire && is_video) |=> (out_valid_o && stream_o))
  `PTS_ASSERT(a_start_load, clk_i, rst_ni, (fire && func_q == FUNC_RESET) |=> (start_q == $past(now_q)))
  `PTS_ASSERT_CLK(a_rst_empty, clk_i, !rst_ni |-> (!out_valid_o && !in_stall_o))

endmodule
